@@ design/tpc_pkg.sv @@
// Package for the peak collector: item types, register indexes, sizes.
// No dependencies.
package tpc_pkg;

    localparam int MAX_PEAKS_DEF = 16;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RADIUS    = 2'd1;
    localparam logic [1:0] REG_MAX_PEAKS = 2'd2;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [31:0] sample;
    } t_in_item;

    typedef struct packed {
        logic               added;
        logic               entry_valid;
        logic signed [15:0] peak_x;
        logic signed [15:0] peak_y;
        logic signed [15:0] peak_z;
        logic signed [31:0] peak_value;
        logic [4:0]         peak_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic               readout;
        logic               below;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [31:0] sample;
    } t_cmd;

    typedef struct packed {
        logic [47:0]        coords;
        logic signed [31:0] value;
    } t_peak;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MIN, S_EVICT, S_READ, S_DONE
    } t_state;

endpackage

@@ design/tpc_front.sv @@
// Front part: takes items, applies the threshold, holds a two-entry command queue.
// Depends on tpc_pkg.
module tpc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_threshold,
    input  logic            i_push,
    input  tpc_pkg::t_in_item i_item,
    output logic            o_full,
    output logic            o_cmd_valid,
    output tpc_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_take
);
    tpc_pkg::t_cmd r_q [2];
    logic          r_rd, r_wr;
    logic [1:0]    r_cnt;
    tpc_pkg::t_cmd w_cmd;
    logic          w_acc;

    assign o_full      = (r_cnt == 2'd2);
    assign w_acc       = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        w_cmd.readout = i_item.kind;
        w_cmd.below   = (i_item.sample < $signed(i_threshold));
        w_cmd.pos_x   = i_item.pos_x;
        w_cmd.pos_y   = i_item.pos_y;
        w_cmd.pos_z   = i_item.pos_z;
        w_cmd.sample  = i_item.sample;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) r_wr <= !r_wr;
            if (i_cmd_take) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_acc) - 2'(i_cmd_take);
        end
    end

`ifndef SYNTHESIS
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> o_cmd_valid) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_cmd_take) |=> o_full) else $error("full dropped without take");
`endif
endmodule

@@ design/tpc_back.sv @@
// Back part: peak list, stored peaks compared one after another, result register.
// Depends on tpc_pkg.
module tpc_back #(
    parameter int MAX_PEAKS = tpc_pkg::MAX_PEAKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [11:0]       i_radius,
    input  logic [4:0]        i_max_peaks,
    input  logic              i_cmd_valid,
    input  tpc_pkg::t_cmd     i_cmd,
    output logic              o_cmd_take,
    output logic              o_empty,
    output tpc_pkg::t_out_item o_item,
    input  logic              i_pop
);
    localparam int IW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CW = $clog2(MAX_PEAKS + 1);

    tpc_pkg::t_peak r_list [MAX_PEAKS];
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_i, n_i, r_j, n_j, r_mi, n_mi;
    logic signed [31:0] r_minv, n_minv;
    tpc_pkg::t_state r_state, n_state;
    tpc_pkg::t_cmd   r_cmd, n_cmd;
    logic            r_rej, n_rej;
    tpc_pkg::t_out_item r_out, n_out;
    logic            r_oval, n_oval;
    tpc_pkg::t_peak  r_rd;
    logic            r_wen;
    logic [IW-1:0]   r_waddr;
    tpc_pkg::t_peak  r_wdata;
    logic            w_wen;
    logic [IW-1:0]   w_waddr;
    tpc_pkg::t_peak  w_wdata;

    // Distance stage: registered squared differences of the current entry.
    logic signed [16:0] w_dx, w_dy, w_dz;
    logic [33:0]        r_sx, r_sy, r_sz;
    logic [23:0]        r_d;
    logic [35:0]        w_sum;
    logic               w_in;
    tpc_pkg::t_peak     w_cur;
    logic [CW:0]        w_cap;

    assign w_cur = r_list[r_i[IW-1:0]];
    assign w_dx = 17'(r_cmd.pos_x) - 17'($signed(w_cur.coords[15:0]));
    assign w_dy = 17'(r_cmd.pos_y) - 17'($signed(w_cur.coords[31:16]));
    assign w_dz = 17'(r_cmd.pos_z) - 17'($signed(w_cur.coords[47:32]));
    assign w_sum = 36'(r_sx) + 36'(r_sy) + 36'(r_sz);
    assign w_in = (r_sx < 34'(r_d)) && (r_sy < 34'(r_d)) && (w_sum < 36'(r_d));

    always_comb begin
        if (i_max_peaks == 5'd0) w_cap = (CW+1)'(1);
        else if ({1'b0, i_max_peaks} > 6'(MAX_PEAKS)) w_cap = (CW+1)'(MAX_PEAKS);
        else w_cap = (CW+1)'(i_max_peaks);
    end

    assign o_empty = !r_oval;
    assign o_item  = r_out;

    // The scan keeps a phase bit: the entry at r_i is squared, then tested.
    logic r_ph, n_ph;

    always_ff @(posedge i_clk) begin
        r_sx <= 34'($signed(w_dx) * $signed(w_dx));
        r_sy <= 34'($signed(w_dy) * $signed(w_dy));
        r_sz <= 34'($signed(w_dz) * $signed(w_dz));
        r_d  <= 24'(i_radius) * 24'(i_radius);
        r_rd <= w_cur;
        if (w_wen) r_list[w_waddr] <= w_wdata;
        r_wen <= w_wen;
        r_waddr <= w_waddr;
        r_wdata <= w_wdata;
        r_cmd <= n_cmd;
        r_out <= n_out;
        r_minv <= n_minv;
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_i = r_i; n_j = r_j; n_mi = r_mi; n_minv = r_minv;
        n_count = r_count; n_rej = r_rej; n_ph = r_ph;
        n_out = r_out; n_oval = r_oval;
        o_cmd_take = 1'b0;
        w_wen = 1'b0; w_waddr = '0; w_wdata = w_cur;
        if (r_oval && i_pop) n_oval = 1'b0;
        case (r_state)
            tpc_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_cmd = i_cmd;
                    n_i = '0; n_j = '0; n_ph = 1'b0; n_rej = 1'b0;
                    if (i_cmd.readout) n_state = tpc_pkg::S_READ;
                    else if (i_cmd.below) begin
                        n_rej = 1'b1; n_state = tpc_pkg::S_DONE;
                    end else n_state = tpc_pkg::S_SCAN;
                end
            end
            // Pass 1 tests for rejection; pass 2 (r_rej set as marker) compacts.
            tpc_pkg::S_SCAN: begin
                if (r_i == r_count) begin
                    if (!r_rej) begin
                        n_rej = 1'b1; n_i = '0; n_j = '0; n_ph = 1'b0;
                    end else begin
                        n_rej = 1'b0;
                        n_count = r_j;
                        n_i = '0; n_ph = 1'b0;
                        if ((CW+1)'(r_j) >= w_cap) n_state = tpc_pkg::S_MIN;
                        else n_state = tpc_pkg::S_EVICT;
                        n_mi = '0;
                        n_minv = r_list[0].value;
                    end
                end else if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    n_i = r_i + 1'b1;
                    if (!r_rej) begin
                        if (w_in && r_rd.value >= r_cmd.sample) begin
                            n_rej = 1'b1; n_state = tpc_pkg::S_DONE;
                        end
                    end else if (!w_in) begin
                        w_wen = 1'b1; w_waddr = r_j[IW-1:0]; w_wdata = r_rd;
                        n_j = r_j + 1'b1;
                    end
                end
            end
            tpc_pkg::S_MIN: begin
                if (r_i == r_count) begin
                    if (r_cmd.sample < r_minv) begin
                        n_rej = 1'b1; n_state = tpc_pkg::S_DONE;
                    end else begin
                        n_i = r_mi; n_count = r_count - 1'b1;
                        n_rej = 1'b1;
                        n_state = tpc_pkg::S_EVICT;
                    end
                end else begin
                    if (w_cur.value < r_minv) begin
                        n_minv = w_cur.value; n_mi = r_i;
                    end
                    n_i = r_i + 1'b1;
                end
            end
            // Shift out the evicted entry (r_rej marks a pending shift), then append.
            tpc_pkg::S_EVICT: begin
                if (r_rej && (r_i < r_count)) begin
                    w_wen = 1'b1; w_waddr = r_i[IW-1:0];
                    w_wdata = r_list[IW'(r_i + 1'b1)];
                    n_i = r_i + 1'b1;
                end else begin
                    n_rej = 1'b0;
                    if (r_count < CW'(MAX_PEAKS)) begin
                        w_wen = 1'b1; w_waddr = r_count[IW-1:0];
                        w_wdata.coords = {r_cmd.pos_z, r_cmd.pos_y, r_cmd.pos_x};
                        w_wdata.value = r_cmd.sample;
                        n_count = r_count + 1'b1;
                    end
                    n_state = tpc_pkg::S_DONE;
                end
            end
            tpc_pkg::S_DONE: begin
                if (!r_oval || i_pop) begin
                    n_oval = 1'b1;
                    n_out = '0;
                    n_out.added = !r_rej;
                    n_out.peak_count = 5'(r_count);
                    n_out.last = 1'b1;
                    n_state = tpc_pkg::S_IDLE;
                end
            end
            tpc_pkg::S_READ: begin
                if (!r_oval || i_pop) begin
                    n_oval = 1'b1;
                    n_out = '0;
                    if (r_count == '0) begin
                        n_out.last = 1'b1;
                        n_state = tpc_pkg::S_IDLE;
                    end else begin
                        n_out.entry_valid = 1'b1;
                        n_out.peak_x = w_cur.coords[15:0];
                        n_out.peak_y = w_cur.coords[31:16];
                        n_out.peak_z = w_cur.coords[47:32];
                        n_out.peak_value = w_cur.value;
                        n_out.last = (r_i + 1'b1 == r_count);
                        n_i = r_i + 1'b1;
                        if (n_out.last) begin
                            n_count = '0; n_state = tpc_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: n_state = tpc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpc_pkg::S_IDLE;
            r_count <= '0;
            r_oval <= 1'b0;
            r_i <= '0; r_j <= '0; r_mi <= '0;
            r_rej <= 1'b0; r_ph <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_oval <= n_oval;
            r_i <= n_i; r_j <= n_j; r_mi <= n_mi;
            r_rej <= n_rej; r_ph <= n_ph;
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PEAKS)) else $error("peak count above depth");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_state == tpc_pkg::S_IDLE)) else $error("take while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !i_pop) |=> (r_oval && $stable(r_out))) else $error("result lost");
    a_wr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wen |-> (r_list[r_waddr] == r_wdata)) else $error("list write lost");
`endif
endmodule

@@ design/top_peak_collector_exclusion_top.sv @@
// Top level of the peak collector with exclusion radius.
// Depends on tpc_pkg, tpc_front and tpc_back.
//
// Voxel items pass a threshold check in the front queue; the back part keeps
// up to MAX_PEAKS peaks and scans them one by one, squaring then testing each, in a
// test pass and a compaction pass, then a minimum pass and a shift pass when full.
// A readout gives one result a cycle while results are popped. The stored peak
// list is the cost.
module top_peak_collector_exclusion_top #(
    parameter int MAX_PEAKS = tpc_pkg::MAX_PEAKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  tpc_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output tpc_pkg::t_out_item o_item
);
    logic [31:0] r_threshold;
    logic [11:0] r_radius;
    logic [4:0]  r_max_peaks;
    logic          w_cv, w_take;
    tpc_pkg::t_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_radius <= '0;
            r_max_peaks <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpc_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                tpc_pkg::REG_RADIUS:    r_radius <= i_cfg_data[11:0];
                tpc_pkg::REG_MAX_PEAKS: r_max_peaks <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    tpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_threshold(r_threshold),
        .i_push(push), .i_item(i_item), .o_full(full),
        .o_cmd_valid(w_cv), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );

    tpc_back #(.MAX_PEAKS(MAX_PEAKS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_radius(r_radius),
        .i_max_peaks(r_max_peaks), .i_cmd_valid(w_cv), .i_cmd(w_cmd),
        .o_cmd_take(w_take), .o_empty(empty), .o_item(o_item), .i_pop(pop)
    );
endmodule

@@ tb/top_peak_collector_exclusion_top_test.sv @@
// Testbench for the peak collector with exclusion radius: directed table, then random items.
// Depends on tpc_pkg and top_peak_collector_exclusion_top; checks results against a local model.
`timescale 1ns / 100ps

module top_peak_collector_exclusion_top_test;

    localparam int NPK = tpc_pkg::MAX_PEAKS_DEF;
    localparam int N_RANDOM = 285;
    localparam int HOLD_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = tpc_pkg::REG_THRESHOLD;
    logic [31:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    tpc_pkg::t_in_item  i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    tpc_pkg::t_out_item o_item;

    top_peak_collector_exclusion_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_item(o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration and the peak list.
    logic signed [31:0] thr_q;
    logic [11:0]        rad_q;
    logic [4:0]         maxp_q;
    logic [47:0]        pk_pos [NPK];
    logic signed [31:0] pk_val [NPK];
    int                 pk_n;

    tpc_pkg::t_out_item expected_results[$];
    int  errors = 0;
    int  results_seen = 0;
    int  readouts_seen = 0;
    int  adds_seen = 0;
    bit  hold_req = 1'b0;

    function automatic bit near(logic [47:0] a, logic [47:0] b);
        longint d;
        longint sq [3];
        longint diff;
        d = longint'(rad_q) * longint'(rad_q);
        for (int k = 0; k < 3; k++) begin
            diff = longint'($signed(a[16*k +: 16])) - longint'($signed(b[16*k +: 16]));
            sq[k] = diff * diff;
        end
        return sq[0] < d && sq[1] < d && (sq[0] + sq[1] + sq[2]) < d;
    endfunction

    function automatic bit try_store(logic [47:0] pos, logic signed [31:0] v);
        int j;
        int cap;
        int mi;
        if (v < thr_q) return 1'b0;
        for (int i = 0; i < pk_n; i++)
            if (pk_val[i] >= v && near(pos, pk_pos[i])) return 1'b0;
        j = 0;
        for (int i = 0; i < pk_n; i++) begin
            if (!near(pos, pk_pos[i])) begin
                pk_pos[j] = pk_pos[i];
                pk_val[j] = pk_val[i];
                j++;
            end
        end
        pk_n = j;
        cap = (maxp_q == 0) ? 1 : (maxp_q > NPK ? NPK : int'(maxp_q));
        if (pk_n >= cap) begin
            mi = 0;
            for (int i = 1; i < pk_n; i++)
                if (pk_val[i] < pk_val[mi]) mi = i;
            if (v < pk_val[mi]) return 1'b0;
            for (int i = mi; i + 1 < pk_n; i++) begin
                pk_pos[i] = pk_pos[i + 1];
                pk_val[i] = pk_val[i + 1];
            end
            pk_n--;
        end
        if (pk_n < NPK) begin
            pk_pos[pk_n] = pos;
            pk_val[pk_n] = v;
            pk_n++;
        end
        return 1'b1;
    endfunction

    function automatic void expect_result(tpc_pkg::t_out_item r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic predict_peaks(tpc_pkg::t_in_item it);
        tpc_pkg::t_out_item r;
        r = '0;
        if (!it.kind) begin
            r.added = try_store({it.pos_z, it.pos_y, it.pos_x}, it.sample);
            r.peak_count = 5'(pk_n);
            r.last = 1'b1;
            expect_result(r);
        end else if (pk_n == 0) begin
            r.last = 1'b1;
            expect_result(r);
        end else begin
            for (int i = 0; i < pk_n; i++) begin
                r = '0;
                r.entry_valid = 1'b1;
                {r.peak_z, r.peak_y, r.peak_x} = pk_pos[i];
                r.peak_value = pk_val[i];
                r.last = (i + 1 == pk_n);
                expect_result(r);
            end
            pk_n = 0;
        end
    endtask

    // Drops push only when a gap follows, so back-to-back items keep it high.
    task automatic idle_cycles();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n != 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tpc_pkg::REG_THRESHOLD: thr_q = data;
            tpc_pkg::REG_RADIUS:    rad_q = data[11:0];
            default:                maxp_q = data[4:0];
        endcase
    endtask

    // Sends one item and waits until it is taken; the prediction is made on acceptance.
    // Push is left high; the caller lowers it before any gap.
    task automatic send_item(tpc_pkg::t_in_item it);
        i_item <= it;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        predict_peaks(it);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic tpc_pkg::t_in_item voxel(int x, int y, int z, int v);
        tpc_pkg::t_in_item it;
        it.kind = 1'b0;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.pos_z = 16'(z);
        it.sample = v;
        return it;
    endfunction

    // Result side: random pop idling, compare on every accepted result.
    initial begin
        tpc_pkg::t_out_item exp_r;
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = 0;
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else if ($urandom_range(0, 3) == 0)
                gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            if (!empty) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", o_item);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_item.entry_valid) readouts_seen++;
                    if (o_item.added) adds_seen++;
                    if (o_item.added !== exp_r.added) begin
                        $error("added: expected %0d actual %0d", exp_r.added, o_item.added);
                        errors++;
                    end
                    if (o_item.entry_valid !== exp_r.entry_valid) begin
                        $error("entry_valid: expected %0d actual %0d",
                               exp_r.entry_valid, o_item.entry_valid);
                        errors++;
                    end
                    if (o_item.peak_x !== exp_r.peak_x) begin
                        $error("peak_x: expected %0d actual %0d", exp_r.peak_x, o_item.peak_x);
                        errors++;
                    end
                    if (o_item.peak_y !== exp_r.peak_y) begin
                        $error("peak_y: expected %0d actual %0d", exp_r.peak_y, o_item.peak_y);
                        errors++;
                    end
                    if (o_item.peak_z !== exp_r.peak_z) begin
                        $error("peak_z: expected %0d actual %0d", exp_r.peak_z, o_item.peak_z);
                        errors++;
                    end
                    if (o_item.peak_value !== exp_r.peak_value) begin
                        $error("peak_value: expected %0d actual %0d",
                               exp_r.peak_value, o_item.peak_value);
                        errors++;
                    end
                    if (o_item.peak_count !== exp_r.peak_count) begin
                        $error("peak_count: expected %0d actual %0d",
                               exp_r.peak_count, o_item.peak_count);
                        errors++;
                    end
                    if (o_item.last !== exp_r.last) begin
                        $error("last: expected %0d actual %0d", exp_r.last, o_item.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Directed table: extremes and special cases.
    typedef struct {
        tpc_pkg::t_in_item  it;
        bit                 typed;
        tpc_pkg::t_out_item res;
    } t_row;

    t_row rows[$];

    task automatic add_row(tpc_pkg::t_in_item it);
        t_row r;
        r.it = it;
        r.typed = 1'b0;
        r.res = '0;
        rows.insert(rows.size(), r);
    endtask

    task automatic add_row_typed(tpc_pkg::t_in_item it, tpc_pkg::t_out_item res);
        t_row r;
        r.it = it;
        r.typed = 1'b1;
        r.res = res;
        rows.insert(rows.size(), r);
    endtask

    function automatic tpc_pkg::t_in_item pick_voxel(int radius);
        tpc_pkg::t_in_item it;
        int s;
        it.kind = 1'b0;
        s = $urandom_range(0, 3);
        // Mostly clustered positions so that the exclusion radius matters.
        if (s == 0) begin
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
            it.pos_z = 16'($urandom);
        end else begin
            it.pos_x = 16'($signed($urandom_range(0, 4 * radius + 8)) - 2 * radius - 4);
            it.pos_y = 16'($signed($urandom_range(0, 4 * radius + 8)) - 2 * radius - 4);
            it.pos_z = 16'($signed($urandom_range(0, 4 * radius + 8)) - 2 * radius - 4);
        end
        s = $urandom_range(0, 4);
        if (s == 0) it.sample = $urandom;
        else it.sample = $signed($urandom_range(0, 400)) - 100;
        return it;
    endfunction

    initial begin
        tpc_pkg::t_in_item it;
        tpc_pkg::t_out_item res;
        int radius;
        thr_q = 0;
        rad_q = 0;
        maxp_q = 5'd16;
        pk_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Readout of the empty list after reset.
        it = '0;
        it.kind = 1'b1;
        res = '0;
        res.last = 1'b1;
        add_row_typed(it, res);
        // Sample at the threshold is kept; below it is dropped.
        res.added = 1'b1;
        res.peak_count = 5'd1;
        add_row_typed(voxel(0, 0, 0, 0), res);
        res.added = 1'b0;
        add_row_typed(voxel(1, 1, 1, -1), res);
        add_row(voxel(-32768, -32768, -32768, 32'h7fffffff));
        add_row(voxel(32767, 32767, 32767, 32'h80000000));
        add_row(voxel(-1, 0, 32767, 5));
        add_row(it);
        for (int i = 0; i < 18; i++) add_row(voxel(i * 100, -i, i, (i * 37) % 11));
        add_row(it);

        // Typed rows are checked directly against the values written in the table.
        foreach (rows[i]) begin
            send_item(rows[i].it);
            if (rows[i].typed) begin
                res = expected_results[expected_results.size() - 1];
                if (res !== rows[i].res) begin
                    $error("table row %0d: expected %p model %p", i, rows[i].res, res);
                    errors++;
                end
                expected_results[expected_results.size() - 1] = rows[i].res;
            end
            idle_cycles();
        end
        drain();

        // Capacity and radius extremes, then random mixes; each phase ends with a readout.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(tpc_pkg::REG_MAX_PEAKS, 0);
                         write_reg(tpc_pkg::REG_RADIUS, 3); end
                1: begin write_reg(tpc_pkg::REG_MAX_PEAKS, 31);
                         write_reg(tpc_pkg::REG_RADIUS, 0); end
                2: begin write_reg(tpc_pkg::REG_MAX_PEAKS, 4);
                         write_reg(tpc_pkg::REG_RADIUS, 10);
                         write_reg(tpc_pkg::REG_THRESHOLD, 32'h80000000); end
                3: begin write_reg(tpc_pkg::REG_MAX_PEAKS, 16);
                         write_reg(tpc_pkg::REG_RADIUS, 4095);
                         write_reg(tpc_pkg::REG_THRESHOLD, 32'h7fffffff); end
                4: begin write_reg(tpc_pkg::REG_THRESHOLD, 50);
                         write_reg(tpc_pkg::REG_RADIUS, 20);
                         write_reg(tpc_pkg::REG_MAX_PEAKS, 8); end
                default: begin write_reg(tpc_pkg::REG_THRESHOLD, 0);
                         write_reg(tpc_pkg::REG_RADIUS, 6);
                         write_reg(tpc_pkg::REG_MAX_PEAKS, 12); end
            endcase
            radius = (rad_q > 40) ? 40 : int'(rad_q);
            // The receiver stalls for a long stretch while items keep coming.
            if (ph == 4) hold_req = 1'b1;
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                // Lowering capacity below the count mid-phase.
                if (ph == 5 && n == 20) begin
                    drain();
                    write_reg(tpc_pkg::REG_MAX_PEAKS, 3);
                end
                if ($urandom_range(0, 14) == 0) begin
                    it = '0;
                    it.kind = 1'b1;
                    it.pos_x = 16'($urandom);
                    it.sample = $urandom;
                end else begin
                    it = pick_voxel(radius);
                end
                send_item(it);
                if (!(ph == 4 && n < 20)) idle_cycles();
            end
            it = '0;
            it.kind = 1'b1;
            send_item(it);
            drain();
        end

        $display("Covered %0d results, %0d stored voxels, %0d read-out peaks.",
                 results_seen, adds_seen, readouts_seen);
        $display("Capacity, radius and threshold extremes and a long result stall exercised.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
